/* hw/rtl/bpc_pkg.sv */
// Shared types and constants for the barometric compensation pipeline.
package bpc_pkg;

   localparam int DIV_STAGES = 64;

   localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
   localparam logic [1:0] REG_PRESS_FIRST = 2'd1;
   localparam logic [1:0] REG_PRESS_MID   = 2'd2;
   localparam logic [1:0] REG_PRESS_LAST  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT      = 2'd2;

   localparam logic signed [26:0] FINE_OFFSET = 27'sd128000;
   localparam logic [20:0]        PRESS_SPAN  = 21'h100000;
   localparam logic [11:0]        PRESS_SCALE = 12'd3125;
   localparam logic signed [29:0] TEMP_ROUND  = 30'sd128;
   localparam logic signed [29:0] TEMP_MUL    = 30'sd5;
   localparam logic [63:0]        PRESS_BIAS  = 64'h0000_8000_0000_0000;
   localparam logic [24:0]        PRESS_MAX   = 25'h1FF_FFFF;
   localparam logic signed [21:0] TEMP_HI     = 22'sd32767;
   localparam logic signed [21:0] TEMP_LO     = -22'sd32768;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic               temp_sat;
      logic               div_zero;
   } side_type;

   typedef struct packed {
      logic [63:0] num;
      logic [30:0] den;
      logic        neg;
      side_type    side;
   } div_req_type;

   typedef struct packed {
      logic [63:0] quo;
      logic        neg;
      side_type    side;
   } div_rsp_type;

endpackage

/* hw/rtl/baro_temp_pressure_compensation_unit.sv */
// Top level of the barometric temperature and pressure compensation unit.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: raw_temperature, raw_pressure
//   rsp      out        rsp_tvalid/rsp_tready  tdata: temperature_centi, pressure_fixed;
//                                              tuser: result_status
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One transfer enters per cycle while req_tready is high; each result passes through the
// 64-stage quotient pipeline plus 13 front and 8 back stages.
// Synchronous active-high reset clears valid bits and calibration registers.
// A stalled result holds every stage in place; req_tready drops with it.
// csr_ready is always high.
module baro_temp_pressure_compensation_unit import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature [19:0], raw_pressure [39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // temperature_centi [15:0], pressure_fixed [40:16], zero
   output logic [1:0]  rsp_tuser,   // result_status [1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] temp_cal_ff, press_first_ff, press_mid_ff, press_last_ff;
   cal_type     cal;
   logic        adv;
   logic        front_valid, div_valid;
   div_req_type front_req;
   div_rsp_type div_rsp;
   logic signed [15:0] out_temp;
   logic [24:0] out_press;
   logic [1:0]  out_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_first_ff <= '0;
         press_mid_ff   <= '0;
         press_last_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP_CAL:    temp_cal_ff    <= csr_data;
            REG_PRESS_FIRST: press_first_ff <= csr_data;
            REG_PRESS_MID:   press_mid_ff   <= csr_data;
            REG_PRESS_LAST:  press_last_ff  <= csr_data;
            default:         temp_cal_ff    <= temp_cal_ff;
         endcase
      end
   end

   assign cal.t1 = temp_cal_ff[15:0];
   assign cal.t2 = $signed(temp_cal_ff[31:16]);
   assign cal.t3 = $signed(temp_cal_ff[47:32]);
   assign cal.p1 = press_first_ff[15:0];
   assign cal.p2 = $signed(press_first_ff[31:16]);
   assign cal.p3 = $signed(press_first_ff[47:32]);
   assign cal.p4 = $signed(press_mid_ff[15:0]);
   assign cal.p5 = $signed(press_mid_ff[31:16]);
   assign cal.p6 = $signed(press_mid_ff[47:32]);
   assign cal.p7 = $signed(press_last_ff[15:0]);
   assign cal.p8 = $signed(press_last_ff[31:16]);
   assign cal.p9 = $signed(press_last_ff[47:32]);

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   bpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cal       (cal),
      .in_valid  (req_tvalid),
      .adc_t     (req_tdata[19:0]),
      .adc_p     (req_tdata[39:20]),
      .out_valid (front_valid),
      .out_req   (front_req)
   );

   bpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_req    (front_req),
      .out_valid (div_valid),
      .out_rsp   (div_rsp)
   );

   bpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cal        (cal),
      .in_valid   (div_valid),
      .in_rsp     (div_rsp),
      .out_valid  (rsp_tvalid),
      .out_temp   (out_temp),
      .out_press  (out_press),
      .out_status (out_status)
   );

   assign rsp_tdata = {7'd0, out_press, out_temp};
   assign rsp_tuser = out_status;

endmodule

/* hw/rtl/bpc_front.sv */
// Front pipeline: fine temperature, temperature output, divisor and dividend.
module bpc_front import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  cal_type     cal,
   input  logic        in_valid,
   input  logic [19:0] adc_t,
   input  logic [19:0] adc_p,
   output logic        out_valid,
   output div_req_type out_req
);

   logic [12:0] vld_ff;

   logic signed [17:0] d1_in, d1_ff;
   logic signed [16:0] d2_in, d2_ff;
   logic [19:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff, p8_ff, p9_ff;
   logic signed [33:0] m1_in, m1_ff, m2_in, m2_ff;
   logic signed [22:0] a_in, a_ff;
   logic signed [38:0] b0_in, b0_ff;
   logic signed [25:0] fine_in, fine_ff;
   logic signed [29:0] tsum;
   logic signed [21:0] tv;
   side_type side_in, s6_ff, s7_ff, s8_ff, s9_ff, s10_ff, s11_ff, s12_ff, s13_ff;
   logic signed [26:0] pa_in, pa_ff;
   logic signed [53:0] sq_in, sq_ff;
   logic signed [42:0] ap5_in, ap5_ff, ap2_in, ap2_ff, ap5b_ff, ap2b_ff, ap5c_ff, ap2c_ff;
   logic signed [48:0] pp6l_in, pp6l_ff, pp3l_in, pp3l_ff;
   logic signed [38:0] pp6h_in, pp6h_ff, pp3h_in, pp3h_ff;
   logic [63:0] v6_in, v6_ff, v3_in, v3_ff;
   logic [63:0] bsum_in, bsum_ff, x_in, x_ff;
   logic [20:0] pdiff;
   logic [63:0] n1_in, n1_ff;
   logic [47:0] xlp_in, xlp_ff;
   logic [31:0] xhp_in, xhp_ff;
   logic [63:0] prod;
   logic signed [30:0] dv_in, dv_ff, dv2_ff;
   logic [43:0] nlp_in, nlp_ff;
   logic [31:0] nhp_in, nhp_ff;
   logic [63:0] n_in, n_ff;
   div_req_type req_in, req_ff;

   assign d1_in = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
   assign d2_in = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, cal.t1});

   assign m1_in = d1_ff * cal.t2;
   assign m2_in = d2_ff * d2_ff;

   assign a_in  = $signed(m1_ff[33:11]);
   assign b0_in = $signed({1'b0, m2_ff[33:12]}) * cal.t3;

   assign fine_in = 26'(a_ff) + 26'($signed(b0_ff[38:14]));

   assign tsum = 30'(fine_ff) * TEMP_MUL + TEMP_ROUND;
   assign tv   = $signed(tsum[29:8]);
   always_comb begin
      side_in = '0;
      priority if (tv > TEMP_HI) begin
         side_in.temp     = 16'sh7FFF;
         side_in.temp_sat = 1'b1;
      end else if (tv < TEMP_LO) begin
         side_in.temp     = -16'sh8000;
         side_in.temp_sat = 1'b1;
      end else begin
         side_in.temp = tv[15:0];
      end
   end
   assign pa_in = 27'(fine_ff) - FINE_OFFSET;

   assign sq_in  = pa_ff * pa_ff;
   assign ap5_in = pa_ff * cal.p5;
   assign ap2_in = pa_ff * cal.p2;

   assign pp6l_in = $signed({1'b0, sq_ff[31:0]}) * cal.p6;
   assign pp6h_in = $signed({1'b0, sq_ff[53:32]}) * cal.p6;
   assign pp3l_in = $signed({1'b0, sq_ff[31:0]}) * cal.p3;
   assign pp3h_in = $signed({1'b0, sq_ff[53:32]}) * cal.p3;

   assign v6_in = 64'(pp6l_ff) + (64'(pp6h_ff) << 32);
   assign v3_in = 64'(pp3l_ff) + (64'(pp3h_ff) << 32);

   assign bsum_in = v6_ff + (64'(ap5c_ff) << 17) + (64'(cal.p4) << 35);
   assign x_in    = 64'($signed(v3_ff) >>> 8) + (64'(ap2c_ff) << 12) + PRESS_BIAS;

   assign pdiff  = PRESS_SPAN - {1'b0, p9_ff};
   assign n1_in  = ({43'd0, pdiff} << 31) - bsum_ff;
   assign xlp_in = x_ff[31:0] * cal.p1;
   assign xhp_in = x_ff[63:32] * cal.p1;

   assign prod   = {16'd0, xlp_ff} + {xhp_ff, 32'd0};
   assign dv_in  = $signed(prod[63:33]);
   assign nlp_in = n1_ff[31:0] * PRESS_SCALE;
   assign nhp_in = n1_ff[63:32] * PRESS_SCALE;

   assign n_in = {20'd0, nlp_ff} + {nhp_ff, 32'd0};

   always_comb begin
      req_in               = '0;
      req_in.num           = n_ff[63] ? (64'd0 - n_ff) : n_ff;
      req_in.den           = dv2_ff[30] ? (31'd0 - dv2_ff) : dv2_ff;
      req_in.neg           = n_ff[63] ^ dv2_ff[30];
      req_in.side          = s13_ff;
      req_in.side.div_zero = (dv2_ff == 31'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[11:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         p1_ff   <= adc_p;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         p2_ff   <= p1_ff;
         a_ff    <= a_in;
         b0_ff   <= b0_in;
         p3_ff   <= p2_ff;
         fine_ff <= fine_in;
         p4_ff   <= p3_ff;
         pa_ff   <= pa_in;
         s6_ff   <= side_in;
         p5_ff   <= p4_ff;
         sq_ff   <= sq_in;
         ap5_ff  <= ap5_in;
         ap2_ff  <= ap2_in;
         s7_ff   <= s6_ff;
         p6_ff   <= p5_ff;
         pp6l_ff <= pp6l_in;
         pp6h_ff <= pp6h_in;
         pp3l_ff <= pp3l_in;
         pp3h_ff <= pp3h_in;
         ap5b_ff <= ap5_ff;
         ap2b_ff <= ap2_ff;
         s8_ff   <= s7_ff;
         p7_ff   <= p6_ff;
         v6_ff   <= v6_in;
         v3_ff   <= v3_in;
         ap5c_ff <= ap5b_ff;
         ap2c_ff <= ap2b_ff;
         s9_ff   <= s8_ff;
         p8_ff   <= p7_ff;
         bsum_ff <= bsum_in;
         x_ff    <= x_in;
         s10_ff  <= s9_ff;
         p9_ff   <= p8_ff;
         n1_ff   <= n1_in;
         xlp_ff  <= xlp_in;
         xhp_ff  <= xhp_in;
         s11_ff  <= s10_ff;
         dv_ff   <= dv_in;
         nlp_ff  <= nlp_in;
         nhp_ff  <= nhp_in;
         s12_ff  <= s11_ff;
         dv2_ff  <= dv_ff;
         n_ff    <= n_in;
         s13_ff  <= s12_ff;
         req_ff  <= req_in;
      end
   end

   assign out_valid = vld_ff[12];
   assign out_req   = req_ff;

endmodule

/* hw/rtl/bpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_req_type in_req,
   output logic        out_valid,
   output div_rsp_type out_rsp
);

   logic [DIV_STAGES-1:0] vld_ff;
   logic [63:0] nq_ff   [DIV_STAGES];
   logic [30:0] rem_ff  [DIV_STAGES];
   logic [30:0] den_ff  [DIV_STAGES];
   logic        neg_ff  [DIV_STAGES];
   side_type    side_ff [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [63:0] nq_cur;
      logic [30:0] rem_cur;
      logic [30:0] den_cur;
      logic        neg_cur;
      side_type    side_cur;
      logic [31:0] shifted;
      logic        ge;
      logic [63:0] nq_in;
      logic [30:0] rem_in;
      logic [31:0] diff;

      if (i == 0) begin : g_first
         assign nq_cur   = in_req.num;
         assign rem_cur  = '0;
         assign den_cur  = in_req.den;
         assign neg_cur  = in_req.neg;
         assign side_cur = in_req.side;
      end else begin : g_next
         assign nq_cur   = nq_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign den_cur  = den_ff[i-1];
         assign neg_cur  = neg_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      assign shifted = {rem_cur, nq_cur[63]};
      assign ge      = (shifted >= {1'b0, den_cur});
      assign diff    = shifted - {1'b0, den_cur};
      assign rem_in  = ge ? diff[30:0] : shifted[30:0];
      assign nq_in   = {nq_cur[62:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[i]   <= nq_in;
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_cur;
            neg_ff[i]  <= neg_cur;
            side_ff[i] <= side_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   assign out_valid    = vld_ff[DIV_STAGES-1];
   assign out_rsp.quo  = nq_ff[DIV_STAGES-1];
   assign out_rsp.neg  = neg_ff[DIV_STAGES-1];
   assign out_rsp.side = side_ff[DIV_STAGES-1];

endmodule

/* hw/rtl/bpc_back.sv */
// Back pipeline: second-order pressure correction, clamp and result register.
module bpc_back import bpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  cal_type            cal,
   input  logic               in_valid,
   input  div_rsp_type        in_rsp,
   output logic               out_valid,
   output logic signed [15:0] out_temp,
   output logic [24:0]        out_press,
   output logic [1:0]         out_status
);

   logic [6:0] vld_ff;
   logic       out_valid_ff;

   side_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff;
   logic [63:0] q_in, q1_ff, q2_ff, q3_ff, q4_ff, q5_ff;
   logic [63:0] s;
   logic [63:0] ssl_in, ssl_ff;
   logic [31:0] sls_in, sls_ff;
   logic signed [48:0] pl8_in, pl8_ff, l9_in, l9_ff;
   logic signed [47:0] ph8_in, ph8_ff, h9_in, h9_ff;
   logic [63:0] sqr_in, sqr_ff, b8_in, b8_ff;
   logic [63:0] b8s_in, b8s_ff, b8t_ff;
   logic [63:0] a9_in, a9_ff;
   logic [63:0] sum_in, sum_ff;
   logic [63:0] pf_in, pf_ff;
   logic signed [15:0] temp_in, temp_ff;
   logic [24:0] press_in, press_ff;
   logic [1:0]  status_in, status_ff;
   logic        psat;

   assign q_in = in_rsp.neg ? (64'd0 - in_rsp.quo) : in_rsp.quo;

   assign s      = 64'($signed(q1_ff) >>> 13);
   assign ssl_in = s[31:0] * s[31:0];
   assign sls_in = s[31:0] * s[63:32];
   assign pl8_in = $signed({1'b0, q1_ff[31:0]}) * cal.p8;
   assign ph8_in = $signed(q1_ff[63:32]) * cal.p8;

   assign sqr_in = ssl_ff + {sls_ff[30:0], 33'd0};
   assign b8_in  = 64'(pl8_ff) + {ph8_ff[31:0], 32'd0};

   assign l9_in  = $signed({1'b0, sqr_ff[31:0]}) * cal.p9;
   assign h9_in  = $signed(sqr_ff[63:32]) * cal.p9;
   assign b8s_in = 64'($signed(b8_ff) >>> 19);

   assign a9_in = 64'(l9_ff) + {h9_ff[31:0], 32'd0};

   assign sum_in = q5_ff + 64'($signed(a9_ff) >>> 25) + b8t_ff;

   assign pf_in = 64'($signed(sum_ff) >>> 8) + (64'(cal.p7) << 4);

   always_comb begin
      psat     = 1'b0;
      press_in = pf_ff[24:0];
      priority if (pf_ff[63]) begin
         psat     = 1'b1;
         press_in = '0;
      end else if (pf_ff[62:25] != '0) begin
         psat     = 1'b1;
         press_in = PRESS_MAX;
      end
      temp_in = s7_ff.temp;
      priority if (s7_ff.div_zero) begin
         press_in  = '0;
         status_in = STATUS_DIV_ZERO;
      end else if (psat || s7_ff.temp_sat) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[5:0], in_valid};
         out_valid_ff <= vld_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff     <= q_in;
         s1_ff     <= in_rsp.side;
         ssl_ff    <= ssl_in;
         sls_ff    <= sls_in;
         pl8_ff    <= pl8_in;
         ph8_ff    <= ph8_in;
         q2_ff     <= q1_ff;
         s2_ff     <= s1_ff;
         sqr_ff    <= sqr_in;
         b8_ff     <= b8_in;
         q3_ff     <= q2_ff;
         s3_ff     <= s2_ff;
         l9_ff     <= l9_in;
         h9_ff     <= h9_in;
         b8s_ff    <= b8s_in;
         q4_ff     <= q3_ff;
         s4_ff     <= s3_ff;
         a9_ff     <= a9_in;
         b8t_ff    <= b8s_ff;
         q5_ff     <= q4_ff;
         s5_ff     <= s4_ff;
         sum_ff    <= sum_in;
         s6_ff     <= s5_ff;
         pf_ff     <= pf_in;
         s7_ff     <= s6_ff;
         temp_ff   <= temp_in;
         press_ff  <= press_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_temp   = temp_ff;
   assign out_press  = press_ff;
   assign out_status = status_ff;

endmodule
